// ----- sv/jes_pkg.sv -----
`default_nettype none
package jes_pkg;
    localparam int unsigned CordicSteps = 24;
    localparam int unsigned FracBits = 20;
    localparam int unsigned SweepMax = 64;
    localparam int unsigned QueueDepth = 4;
    localparam logic [63:0] InvGainQ30 = 64'd652032874;
    localparam logic [63:0] NormLimit = 64'd1 << 40;
    localparam logic [63:0] Pi4Q30 = 64'd843314857;

    localparam logic [0:0] RegSweep = 1'b0;
    localparam logic [0:0] RegTol = 1'b1;

    typedef struct packed {
        logic [2:0]  index;
        logic [31:0] value;
        logic        last;
    } t_word;

    function automatic logic [63:0] atan_q30(input logic [4:0] i);
        logic [63:0] v;
        unique case (i)
            5'd0: v = 64'd843314857;
            5'd1: v = 64'd497837829;
            5'd2: v = 64'd263043837;
            5'd3: v = 64'd133525159;
            5'd4: v = 64'd67021687;
            5'd5: v = 64'd33543516;
            5'd6: v = 64'd16775851;
            5'd7: v = 64'd8388437;
            5'd8: v = 64'd4194283;
            5'd9: v = 64'd2097149;
            5'd31: v = 64'd0;
            default: v = 64'd1 << (5'd30 - i);
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) r = 32'sh7fffffff;
        else if (v < -64'sd2147483648) r = 32'sh80000000;
        else r = v[31:0];
        return r;
    endfunction
endpackage
`default_nettype wire

// ----- sv/jes_front.sv -----
`default_nettype none
// input word queue between the port and the rotation engine
module jes_front #(
    parameter int unsigned DEPTH = jes_pkg::QueueDepth
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  jes_pkg::t_word   i_word,
    output logic             o_full,
    output logic             o_valid,
    output jes_pkg::t_word   o_word,
    input  wire              i_take
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    jes_pkg::t_word r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic do_push, do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_word  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (do_pop)  r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(DEPTH)) else $error("queue count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |=> !($past(do_push) && !$past(do_pop) && r_cnt == '0))
        else $error("push while full");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_pop && !do_push) |=> r_cnt == $past(r_cnt) - 1'b1)
        else $error("pop count");
endmodule
`default_nettype wire

// ----- sv/jes_back.sv -----
`default_nettype none
// rotation engine: one cordic step or one product per cycle
module jes_back #(
    parameter int unsigned CORDIC_STEPS = jes_pkg::CordicSteps
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    input  jes_pkg::t_word    i_word,
    output logic              o_take,
    input  wire  [6:0]        i_sweep,
    input  wire  [30:0]       i_tol,
    output logic              o_res_valid,
    input  wire               i_res_take,
    output logic signed [31:0] o_diag0,
    output logic signed [31:0] o_diag1,
    output logic signed [31:0] o_diag2,
    output logic              o_conv
);
    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001, S_PIV = 10'b0000000010, S_LOAD = 10'b0000000100,
        S_NORM = 10'b0000001000, S_VEC = 10'b0000010000, S_ROT = 10'b0000100000,
        S_MUL  = 10'b0001000000, S_SUM = 10'b0010000000, S_WR  = 10'b0100000000,
        S_OUT  = 10'b1000000000
    } t_state;

    t_state r_st;
    logic signed [31:0] r_m [6];
    logic [6:0] r_rot, r_runs;
    logic [4:0] r_i;
    logic [3:0] r_k;
    logic [2:0] r_ipp, r_iqq, r_ipq, r_irp, r_irq;
    logic signed [63:0] r_x, r_y, r_z, r_c, r_s, r_cc, r_ss, r_cs;
    logic signed [63:0] r_p [9];
    logic signed [31:0] r_npp, r_nqq, r_nrp, r_nrq;
    logic r_rv;
    logic signed [31:0] r_d0, r_d1, r_d2;
    logic r_cv;

    logic [4:0] steps_m1;
    assign steps_m1 = 5'(CORDIC_STEPS - 1);
    assign o_take = (r_st == S_IDLE);

    function automatic logic signed [63:0] rnd(input logic signed [63:0] v);
        return (v + 64'sd536870912) >>> 30;
    endfunction

    function automatic logic signed [63:0] mg(input logic signed [31:0] v);
        return v[31] ? -64'(v) : 64'(v);
    endfunction

    logic signed [63:0] m01, m02, m12, dx, dy, at, d;
    logic signed [32:0] ma;
    logic signed [31:0] mb;
    logic signed [64:0] prod;
    assign m01 = mg(r_m[1]);
    assign m02 = mg(r_m[2]);
    assign m12 = mg(r_m[4]);
    assign dx = r_y >>> r_i;
    assign dy = r_x >>> r_i;
    assign at = signed'(jes_pkg::atan_q30(r_i));
    assign d = 64'(r_m[r_iqq]) - 64'(r_m[r_ipp]);

    // cos and sin stay within 2^31, so a 33x32 multiplier covers every product
    always_comb begin
        unique case (r_k)
            4'd0:  begin ma = r_c[32:0];  mb = r_c[31:0]; end
            4'd1:  begin ma = r_s[32:0];  mb = r_s[31:0]; end
            4'd2:  begin ma = r_c[32:0];  mb = r_s[31:0]; end
            4'd3:  begin ma = r_cc[32:0]; mb = r_m[r_ipp]; end
            4'd4:  begin ma = r_cs[32:0]; mb = r_m[r_ipq]; end
            4'd5:  begin ma = r_ss[32:0]; mb = r_m[r_iqq]; end
            4'd6:  begin ma = r_ss[32:0]; mb = r_m[r_ipp]; end
            4'd7:  begin ma = r_cc[32:0]; mb = r_m[r_iqq]; end
            4'd8:  begin ma = r_c[32:0];  mb = r_m[r_irp]; end
            4'd9:  begin ma = r_s[32:0];  mb = r_m[r_irq]; end
            4'd10: begin ma = r_s[32:0];  mb = r_m[r_irp]; end
            default: begin ma = r_c[32:0]; mb = r_m[r_irq]; end
        endcase
    end
    assign prod = ma * mb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_rv <= 1'b0;
            r_rot <= '0;
        end else begin
            if (i_res_take && r_rv && r_st != S_OUT) r_rv <= 1'b0;
            unique case (r_st)
                S_IDLE: if (i_valid) begin
                    if (i_word.index < 3'd6) r_m[i_word.index] <= i_word.value;
                    if (i_word.last) begin
                        r_runs <= (i_sweep > 7'd64) ? 7'd64 : i_sweep;
                        r_rot <= '0;
                        r_st <= S_PIV;
                    end
                end
                S_PIV: begin
                    if (r_rot == r_runs) r_st <= S_OUT;
                    else if (m12 >= m01 && m12 >= m02) begin
                        // all three zero: nothing to rotate
                        if (m12 == 0) r_rot <= r_rot + 1'b1;
                        else begin
                            r_ipp <= 3'd3; r_iqq <= 3'd5; r_ipq <= 3'd4;
                            r_irp <= 3'd1; r_irq <= 3'd2; r_st <= S_LOAD;
                        end
                    end else if (m02 >= m01) begin
                        r_ipp <= 3'd0; r_iqq <= 3'd5; r_ipq <= 3'd2;
                        r_irp <= 3'd1; r_irq <= 3'd4; r_st <= S_LOAD;
                    end else begin
                        r_ipp <= 3'd0; r_iqq <= 3'd3; r_ipq <= 3'd1;
                        r_irp <= 3'd2; r_irq <= 3'd4; r_st <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_i <= '0;
                    if (d == 0) begin
                        r_z <= signed'(jes_pkg::Pi4Q30);
                        r_x <= signed'(jes_pkg::InvGainQ30);
                        r_y <= '0;
                        r_st <= S_ROT;
                    end else begin
                        r_z <= '0;
                        r_x <= d[63] ? -d : d;
                        r_y <= d[63] ? -(64'(r_m[r_ipq]) <<< 1) : (64'(r_m[r_ipq]) <<< 1);
                        r_st <= S_NORM;
                    end
                end
                S_NORM: begin
                    if (r_x < signed'(jes_pkg::NormLimit) && r_y < signed'(jes_pkg::NormLimit)
                        && -r_y < signed'(jes_pkg::NormLimit)) begin
                        r_x <= r_x <<< 1;
                        r_y <= r_y <<< 1;
                    end else r_st <= S_VEC;
                end
                S_VEC: begin
                    if (r_i == steps_m1) begin
                        r_i <= '0;
                        r_x <= signed'(jes_pkg::InvGainQ30);
                        r_y <= '0;
                        r_z <= (r_y[63] ? r_z - at : r_z + at) >>> 1;
                        r_st <= S_ROT;
                    end else begin
                        r_i <= r_i + 1'b1;
                        if (r_y[63]) begin
                            r_x <= r_x - dx; r_y <= r_y + dy; r_z <= r_z - at;
                        end else begin
                            r_x <= r_x + dx; r_y <= r_y - dy; r_z <= r_z + at;
                        end
                    end
                end
                S_ROT: begin
                    if (!r_z[63]) begin
                        r_x <= r_x - dx; r_y <= r_y + dy; r_z <= r_z - at;
                    end else begin
                        r_x <= r_x + dx; r_y <= r_y - dy; r_z <= r_z + at;
                    end
                    if (r_i == steps_m1) begin
                        r_c <= r_z[63] ? r_x + dx : r_x - dx;
                        r_s <= r_z[63] ? r_y - dy : r_y + dy;
                        r_k <= '0;
                        r_st <= S_MUL;
                    end else r_i <= r_i + 1'b1;
                end
                S_MUL: begin
                    // squares and the c*s term first, then the matrix products, one product per cycle
                    unique case (r_k)
                        4'd0: r_cc <= rnd(prod[63:0]);
                        4'd1: r_ss <= rnd(prod[63:0]);
                        4'd2: r_cs <= rnd(prod[63:0]);
                        default: r_p[r_k - 4'd3] <= prod[63:0];
                    endcase
                    r_k <= r_k + 1'b1;
                    if (r_k == 4'd11) r_st <= S_SUM;
                end
                S_SUM: begin
                    r_npp <= jes_pkg::sat32(rnd(r_p[0] - (r_p[1] <<< 1) + r_p[2]));
                    r_nqq <= jes_pkg::sat32(rnd(r_p[3] + (r_p[1] <<< 1) + r_p[4]));
                    r_nrp <= jes_pkg::sat32(rnd(r_p[5] - r_p[6]));
                    r_nrq <= jes_pkg::sat32(rnd(r_p[7] + r_p[8]));
                    r_st <= S_WR;
                end
                S_WR: begin
                    r_m[r_ipp] <= r_npp;
                    r_m[r_iqq] <= r_nqq;
                    r_m[r_ipq] <= '0;
                    r_m[r_irp] <= r_nrp;
                    r_m[r_irq] <= r_nrq;
                    r_rot <= r_rot + 1'b1;
                    r_st <= S_PIV;
                end
                S_OUT: if (!r_rv || i_res_take) begin
                    r_d0 <= r_m[0]; r_d1 <= r_m[3]; r_d2 <= r_m[5];
                    r_cv <= m01 <= 64'(i_tol) && m02 <= 64'(i_tol) && m12 <= 64'(i_tol);
                    r_rv <= 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_res_valid = r_rv;
    assign o_diag0 = r_d0;
    assign o_diag1 = r_d1;
    assign o_diag2 = r_d2;
    assign o_conv = r_cv;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_st)) else $error("state not one-hot");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rot <= 7'd64) else $error("rotation count");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_OUT && r_rv && !i_res_take) |=> r_st == S_OUT)
        else $error("result overwritten");
endmodule
`default_nettype wire

// ----- sv/jacobi_eigen_3x3_symmetric_core.sv -----
// timing: per rotation the engine normalizes, then the shared cordic stage vectors and rotates,
// one micro-rotation per cycle; normalizing and vectoring are skipped when the two diagonals are
// equal; rotations repeat sweep_count times (at most 64), then the result is posted
// throughput: one matrix at a time; loads are one word per cycle while the 4-word queue is not full
// reset: synchronous active low; sweep_count 2, tolerance 10, queue and result cleared
`default_nettype none
module jacobi_eigen_3x3_symmetric_core #(
    parameter int unsigned CORDIC_STEPS = jes_pkg::CordicSteps
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               push,
    output logic              full,
    input  wire  [2:0]        i_elem_index,
    input  wire  [31:0]       i_elem_value,
    input  wire               i_last_elem,
    output logic              empty,
    input  wire               pop,
    output logic signed [31:0] o_diag0,
    output logic signed [31:0] o_diag1,
    output logic signed [31:0] o_diag2,
    output logic              o_converged,
    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire  [2:0]        paddr,
    input  wire  [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    logic [6:0] r_sweep;
    logic [30:0] r_tol;
    jes_pkg::t_word in_w, q_w;
    logic q_valid, q_take, res_valid;

    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= 7'd2;
            r_tol <= 31'd10;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                jes_pkg::RegSweep: r_sweep <= pwdata[6:0];
                jes_pkg::RegTol: r_tol <= pwdata[30:0];
                default: ;
            endcase
        end
    end
    assign prdata = paddr[2] ? {1'b0, r_tol} : {25'd0, r_sweep};

    assign in_w = '{index: i_elem_index, value: i_elem_value, last: i_last_elem};

    jes_front u_front (
        .i_clk, .i_rst_n, .i_push(push), .i_word(in_w), .o_full(full),
        .o_valid(q_valid), .o_word(q_w), .i_take(q_take)
    );

    jes_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .i_word(q_w), .o_take(q_take),
        .i_sweep(r_sweep), .i_tol(r_tol), .o_res_valid(res_valid),
        .i_res_take(pop), .o_diag0, .o_diag1, .o_diag2, .o_conv(o_converged)
    );
    assign empty = !res_valid;
endmodule
`default_nettype wire

// ----- bench/jes_checker.sv -----
`default_nettype none
module jes_checker (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               push,
    input  wire               full,
    input  wire  [2:0]        elem_index,
    input  wire  [31:0]       elem_value,
    input  wire               last_elem,
    input  wire               empty,
    input  wire               pop,
    input  wire signed [31:0] diag0,
    input  wire signed [31:0] diag1,
    input  wire signed [31:0] diag2,
    input  wire               converged,
    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire               pready,
    input  wire  [2:0]        paddr,
    input  wire  [31:0]       pwdata,
    output int                o_pending,
    output int                o_fails
);
    typedef struct {
        logic signed [31:0] d0;
        logic signed [31:0] d1;
        logic signed [31:0] d2;
        logic               conv;
    } t_eigen;

    localparam longint ScaleLim = 64'sd1 <<< 40;
    localparam longint InvGain = 64'sd652032874;

    longint angle_tab[32] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8, 4, 2, 1, 0
    };

    logic [6:0]         sweeps;
    logic [30:0]        tol;
    logic signed [31:0] mtx[6];
    t_eigen             eigen_q[$];

    function automatic int slot(input int r, input int c);
        int map[9] = '{0, 1, 2, 1, 3, 4, 2, 4, 5};
        return map[r * 3 + c];
    endfunction

    function automatic longint mag(input logic signed [31:0] v);
        longint w;
        w = v;
        return (w < 0) ? -w : w;
    endfunction

    function automatic longint rnd30(input longint v);
        return (v + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic logic signed [31:0] clip32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // arctangent by vectoring, x positive
    function automatic longint vec_atan(input longint x0, input longint y0);
        longint x, y, z, dx, dy;
        x = x0;
        y = y0;
        z = 0;
        while (x < ScaleLim && y < ScaleLim && -y < ScaleLim) begin
            x = x * 2;
            y = y * 2;
        end
        for (int i = 0; i < jes_pkg::CordicSteps; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y < 0) begin
                x -= dx; y += dy; z -= angle_tab[i % 32];
            end else begin
                x += dx; y -= dy; z += angle_tab[i % 32];
            end
        end
        return z;
    endfunction

    task automatic rot_cs(input longint z0, output longint c, output longint s);
        longint x, y, z, dx, dy;
        x = InvGain;
        y = 0;
        z = z0;
        for (int i = 0; i < jes_pkg::CordicSteps; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= angle_tab[i % 32];
            end else begin
                x += dx; y -= dy; z += angle_tab[i % 32];
            end
        end
        c = x;
        s = y;
    endtask

    task automatic jacobi_rotate();
        int p, q, r, pa[3], qa[3];
        longint best, m, app, aqq, apq, arp, arq, d, th, c, s, cc, ss, cs;
        pa = '{0, 0, 1};
        qa = '{1, 2, 2};
        best = -1;
        p = 0;
        q = 1;
        for (int k = 0; k < 3; k++) begin
            m = mag(mtx[slot(pa[k], qa[k])]);
            // ties go to the later pair
            if (m >= best) begin
                best = m; p = pa[k]; q = qa[k];
            end
        end
        if (best == 0) return;
        r = 3 - p - q;
        app = mtx[slot(p, p)];
        aqq = mtx[slot(q, q)];
        apq = mtx[slot(p, q)];
        arp = mtx[slot(r, p)];
        arq = mtx[slot(r, q)];
        d = aqq - app;
        if (d == 0) th = angle_tab[0];
        else if (d > 0) th = vec_atan(d, 2 * apq) >>> 1;
        else th = vec_atan(-d, -2 * apq) >>> 1;
        rot_cs(th, c, s);
        cc = rnd30(c * c);
        ss = rnd30(s * s);
        cs = rnd30(c * s);
        mtx[slot(p, p)] = clip32(rnd30(cc * app - 2 * cs * apq + ss * aqq));
        mtx[slot(q, q)] = clip32(rnd30(ss * app + 2 * cs * apq + cc * aqq));
        mtx[slot(p, q)] = '0;
        mtx[slot(r, p)] = clip32(rnd30(c * arp - s * arq));
        mtx[slot(r, q)] = clip32(rnd30(s * arp + c * arq));
    endtask

    task automatic load_word(input logic [2:0] idx, input logic [31:0] val, input logic lst);
        t_eigen e;
        int runs;
        if (idx < 6) mtx[idx] = val;
        if (!lst) return;
        runs = (sweeps > jes_pkg::SweepMax) ? jes_pkg::SweepMax : sweeps;
        for (int k = 0; k < runs; k++) jacobi_rotate();
        e.d0 = mtx[0];
        e.d1 = mtx[3];
        e.d2 = mtx[5];
        e.conv = mag(mtx[1]) <= tol && mag(mtx[2]) <= tol && mag(mtx[4]) <= tol;
        eigen_q.push_back(e);
    endtask

    initial o_fails = 0;

    // sampled mid-cycle, so handshakes are stable until the next rising edge
    always @(negedge i_clk) begin
        t_eigen e;
        if (!i_rst_n) begin
            sweeps = 7'd2;
            tol = 31'd10;
            eigen_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == jes_pkg::RegSweep) sweeps = pwdata[6:0];
                else tol = pwdata[30:0];
            end
            if (push && !full) load_word(elem_index, elem_value, last_elem);
            if (pop && !empty) begin
                if (eigen_q.size() == 0) begin
                    $error("result word with nothing expected");
                    o_fails++;
                end else begin
                    e = eigen_q.pop_front();
                    if (diag0 !== e.d0) begin
                        $error("diag0 expected %0d got %0d", e.d0, diag0);
                        o_fails++;
                    end
                    if (diag1 !== e.d1) begin
                        $error("diag1 expected %0d got %0d", e.d1, diag1);
                        o_fails++;
                    end
                    if (diag2 !== e.d2) begin
                        $error("diag2 expected %0d got %0d", e.d2, diag2);
                        o_fails++;
                    end
                    if (converged !== e.conv) begin
                        $error("converged expected %0d got %0d", e.conv, converged);
                        o_fails++;
                    end
                end
            end
        end
        o_pending = eigen_q.size();
    end
endmodule
`default_nettype wire

// ----- bench/tb_jacobi_eigen_3x3_symmetric_core.sv -----
`default_nettype none
module tb_jacobi_eigen_3x3_symmetric_core;
    localparam int StallLimit = 40000;
    localparam logic [2:0] AddrSweep = {jes_pkg::RegSweep, 2'b00};
    localparam logic [2:0] AddrTol = {jes_pkg::RegTol, 2'b00};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic [2:0]  elem_index = '0;
    logic [31:0] elem_value = '0;
    logic        last_elem = 1'b0;
    logic        pop = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;

    wire               full, empty, o_converged, pready;
    wire signed [31:0] o_diag0, o_diag1, o_diag2;
    wire [31:0]        prdata;
    int                pending, fails;

    logic in_hit = 1'b0, out_hit = 1'b0, bursty = 1'b0;
    int   stall_cnt = 0;

    always #5 i_clk = ~i_clk;

    jacobi_eigen_3x3_symmetric_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full),
        .i_elem_index(elem_index), .i_elem_value(elem_value), .i_last_elem(last_elem),
        .empty(empty), .pop(pop),
        .o_diag0(o_diag0), .o_diag1(o_diag1), .o_diag2(o_diag2), .o_converged(o_converged),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    jes_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full),
        .elem_index(elem_index), .elem_value(elem_value), .last_elem(last_elem),
        .empty(empty), .pop(pop),
        .diag0(o_diag0), .diag1(o_diag1), .diag2(o_diag2), .converged(o_converged),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .o_pending(pending), .o_fails(fails)
    );

    always @(negedge i_clk) begin
        in_hit <= push && !full;
        out_hit <= pop && !empty;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || in_hit || out_hit || psel) stall_cnt <= 0;
        else stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= StallLimit) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int draw_gap();
        return bursty ? 0 : $urandom_range(0, 13);
    endfunction

    // result side
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (!out_hit);
        end
    end

    task automatic send_word(input logic [2:0] idx, input logic [31:0] val, input logic lst);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        elem_index <= idx;
        elem_value <= val;
        last_elem <= lst;
        do @(posedge i_clk); while (!in_hit);
    endtask

    task automatic settle();
        push <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        // a word without a result may still sit in the load queue
        repeat (120) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_entry();
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return '0;
            3, 4: return $urandom;
            default: return $urandom_range(0, 32'h0fffffff) - 32'h08000000;
        endcase
    endfunction

    task automatic send_matrix();
        int ord[6], j, t, n;
        if ($urandom_range(0, 6) != 0) begin
            // well-formed: all six entries in shuffled order, some ignored indexes between
            for (int k = 0; k < 6; k++) ord[k] = k;
            for (int k = 5; k > 0; k--) begin
                j = $urandom_range(0, k);
                t = ord[k]; ord[k] = ord[j]; ord[j] = t;
            end
            for (int k = 0; k < 6; k++) begin
                if ($urandom_range(0, 15) == 0)
                    send_word(3'($urandom_range(6, 7)), $urandom, 1'b0);
                send_word(3'(ord[k]), rand_entry(), k == 5);
            end
        end else begin
            n = $urandom_range(1, 8);
            for (int k = 0; k < n; k++)
                send_word(3'($urandom_range(0, 7)), rand_entry(), k == n - 1);
        end
    endtask

    task automatic run_phase(input logic [31:0] sw, input logic [31:0] tl, input int mats);
        settle();
        reg_write(AddrSweep, sw);
        reg_write(AddrTol, tl);
        for (int m = 0; m < mats; m++) begin
            if (m % 8 == 0) bursty = ($urandom_range(0, 3) == 0);
            send_matrix();
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // diagonal matrix, nothing to rotate
        send_word(3'd0, 32'h00100000, 1'b0);
        send_word(3'd1, 32'h00000000, 1'b0);
        send_word(3'd2, 32'h00000000, 1'b0);
        send_word(3'd3, 32'h00200000, 1'b0);
        send_word(3'd4, 32'h00000000, 1'b0);
        send_word(3'd5, 32'h00300000, 1'b1);
        // two equal diagonals and equal off-diagonal magnitudes, last on an ignored index
        send_word(3'd1, 32'h00500000, 1'b0);
        send_word(3'd2, 32'hffb00000, 1'b0);
        send_word(3'd4, 32'h00500000, 1'b0);
        send_word(3'd0, 32'h00100000, 1'b0);
        send_word(3'd3, 32'h00100000, 1'b0);
        send_word(3'd6, 32'hdeadbeef, 1'b1);
        // full-scale entries
        send_word(3'd0, 32'h7fffffff, 1'b0);
        send_word(3'd3, 32'h80000000, 1'b0);
        send_word(3'd5, 32'h7fffffff, 1'b0);
        send_word(3'd1, 32'h80000000, 1'b0);
        send_word(3'd7, 32'h21524110, 1'b1);
        send_word(3'd2, 32'h7fffffff, 1'b0);
        send_word(3'd4, 32'h80000001, 1'b1);
        send_word(3'd5, 32'h00000000, 1'b1);

        run_phase(32'd1, 32'd0, 40);
        run_phase(32'd3, $urandom_range(0, 32'h7fffffff), 40);
        run_phase(32'd0, $urandom, 15);
        run_phase(32'd127, 32'h7fffffff, 3);
        run_phase(32'd64, 32'd1000, 3);
        run_phase(32'd8, $urandom, 30);
        run_phase(32'd4, 32'd4096, 50);

        settle();
        if (fails == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
